// File: rtl/core/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LASS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LASS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lass_pkg.sv
// Package for the least-attained-service scheduler: sizes, codes, the token
// passed along the flow cells and the commit command. No dependencies.
`default_nettype none

package lass_pkg;

  localparam int unsigned NUM_FLOWS        = 16;
  localparam int unsigned FLOW_QUEUE_DEPTH = 16;

  localparam int unsigned FLOW_W      = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
  localparam int unsigned IDX_W       = (FLOW_QUEUE_DEPTH > 1) ? $clog2(FLOW_QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(FLOW_QUEUE_DEPTH + 1);
  localparam int unsigned STORE_DEPTH = NUM_FLOWS * FLOW_QUEUE_DEPTH;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  localparam int unsigned REQ_FLOW_W = 4;
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned SVC_W      = 32;
  localparam int unsigned DESC_W     = TAG_W + SIZE_W;
  localparam int unsigned STATUS_W   = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_ENQ  = 2'd1,
    CMD_DEQ  = 2'd2
  } cmd_op_e;

  // Token that walks the chain of flow cells, one cell per cycle.
  typedef struct packed {
    logic                  vld;
    logic                  deq;
    logic [REQ_FLOW_W-1:0] req_flow;
    logic                  found;
    logic [FLOW_W-1:0]     id;
    logic [SVC_W-1:0]      svc;
    logic [CNT_W-1:0]      cnt;
    logic [IDX_W-1:0]      idx;
  } tok_t;

  // Commit broadcast to all cells once a transaction is resolved.
  typedef struct packed {
    cmd_op_e           op;
    logic [FLOW_W-1:0] flow;
    logic [SIZE_W-1:0] size;
  } cmd_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    logic [31:0] nxt;
    nxt = 32'(i) + 32'd1;
    return (nxt >= FLOW_QUEUE_DEPTH) ? '0 : IDX_W'(nxt);
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [FLOW_W-1:0] flow,
                                                   input logic [IDX_W-1:0]  idx);
    return ADDR_W'(32'(flow) * FLOW_QUEUE_DEPTH + 32'(idx));
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/least_attained_service_scheduler.sv
// Least-attained-service packet scheduler, top level.
// Depends on lass_pkg, lass_cell, lass_ram and assert_macros.svh.
//
// Usage:
//   Requests arrive on the in_* valid/ready channel: req_type_i 0 enqueues
//   the descriptor (pkt_tag_i, pkt_size_i) on flow flow_id_i, 1 dequeues the
//   packet of the non-empty flow with the least attained service (lowest id
//   on a tie). Each request gives exactly one result on the out_* channel.
//   A request is resolved by a token that walks a chain of NUM_FLOWS flow
//   cells, one cell per cycle. An enqueue result is formed once the token
//   leaves the last cell, a dequeue result after the descriptor RAM read
//   as well. The block returns to idle as the result is loaded into the
//   output register, and takes one request at a time. A new request is
//   accepted while a previous result still waits in the output register;
//   if the receiver stalls, the next result waits in the block until the
//   output register is free.
//   Reset clears all flow counters, FIFO pointers and fills at once; the
//   descriptor RAM is not cleared, since only written entries are read.
`include "assert_macros.svh"
`default_nettype none

module least_attained_service_scheduler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [lass_pkg::REQ_FLOW_W-1:0] flow_id_i,
  input  logic [lass_pkg::TAG_W-1:0]      pkt_tag_i,
  input  logic [lass_pkg::SIZE_W-1:0]     pkt_size_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lass_pkg::STATUS_W-1:0]   status_o,
  output logic [lass_pkg::REQ_FLOW_W-1:0] out_flow_o,
  output logic [lass_pkg::TAG_W-1:0]      out_tag_o,
  output logic [lass_pkg::SIZE_W-1:0]     out_size_o
);
  import lass_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_DONE
  } state_e;

  state_e                state_q;
  tok_t                  tok [NUM_FLOWS+1];
  tok_t                  tok_end;
  cmd_t                  cmd;
  logic                  scan_done;
  logic                  enq_ok;
  logic                  ram_we;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_addr;
  logic [DESC_W-1:0]     ram_rdata;
  logic                  out_free;
  logic [31:0]           rd_id_wide;

  logic [TAG_W-1:0]      req_tag_q;
  logic [SIZE_W-1:0]     req_size_q;
  logic [FLOW_W-1:0]     rd_id_q;
  status_e               res_status_q;
  logic [REQ_FLOW_W-1:0] res_flow_q;
  logic [TAG_W-1:0]      res_tag_q;
  logic [SIZE_W-1:0]     res_size_q;
  logic                  out_valid_q;
  status_e               out_status_q;
  logic [REQ_FLOW_W-1:0] out_flow_q;
  logic [TAG_W-1:0]      out_tag_q;
  logic [SIZE_W-1:0]     out_size_q;

  assign in_ready_o = (state_q == S_IDLE);

  // Inject a fresh token into the first cell on every accepted transaction.
  always_comb begin
    tok[0]          = '0;
    tok[0].vld      = in_valid_i && in_ready_o;
    tok[0].deq      = req_type_i;
    tok[0].req_flow = flow_id_i;
  end

  for (genvar i = 0; i < NUM_FLOWS; i++) begin : g_cell
    lass_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (FLOW_W'(i)),
      .tok_i     (tok[i]),
      .tok_o     (tok[i+1]),
      .cmd_i     (cmd)
    );
  end

  always_comb begin
    tok_end    = tok[NUM_FLOWS];
    scan_done  = (state_q == S_SCAN) && tok_end.vld;
    enq_ok     = !tok_end.deq && tok_end.found &&
                 (tok_end.cnt < CNT_W'(FLOW_QUEUE_DEPTH));
    ram_we     = scan_done && enq_ok;
    ram_re     = scan_done && tok_end.deq && tok_end.found;
    ram_addr   = store_addr(tok_end.id, tok_end.idx);
    out_free   = !out_valid_q || out_ready_i;
    rd_id_wide = 32'(rd_id_q);
  end

  // Commit the state change to the owning cell.
  always_comb begin
    cmd = '{op: CMD_NONE, flow: '0, size: '0};
    if (ram_we) begin
      cmd.op   = CMD_ENQ;
      cmd.flow = tok_end.id;
    end else if (state_q == S_READ) begin
      cmd.op   = CMD_DEQ;
      cmd.flow = rd_id_q;
      cmd.size = ram_rdata[SIZE_W-1:0];
    end
  end

  lass_ram #(
    .DATA_W (DESC_W),
    .DEPTH  (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i ({req_tag_q, req_size_q}),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      req_tag_q    <= '0;
      req_size_q   <= '0;
      rd_id_q      <= '0;
      res_status_q <= ST_ENQUEUED;
      res_flow_q   <= '0;
      res_tag_q    <= '0;
      res_size_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_ENQUEUED;
      out_flow_q   <= '0;
      out_tag_q    <= '0;
      out_size_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_tag_q  <= pkt_tag_i;
            req_size_q <= pkt_size_i;
            state_q    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (tok_end.vld) begin
            res_tag_q  <= '0;
            res_size_q <= '0;
            if (tok_end.deq) begin
              if (tok_end.found) begin
                rd_id_q <= tok_end.id;
                state_q <= S_READ;
              end else begin
                res_status_q <= ST_EMPTY;
                res_flow_q   <= '0;
                state_q      <= S_DONE;
              end
            end else begin
              res_status_q <= enq_ok ? ST_ENQUEUED : ST_DROPPED;
              res_flow_q   <= tok_end.req_flow;
              state_q      <= S_DONE;
            end
          end
        end
        S_READ: begin
          res_status_q <= ST_DEQUEUED;
          res_flow_q   <= rd_id_wide[REQ_FLOW_W-1:0];
          res_tag_q    <= ram_rdata[DESC_W-1:SIZE_W];
          res_size_q   <= ram_rdata[SIZE_W-1:0];
          state_q      <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_flow_q   <= res_flow_q;
            out_tag_q    <= res_tag_q;
            out_size_q   <= res_size_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign out_flow_o  = out_flow_q;
  assign out_tag_o   = out_tag_q;
  assign out_size_o  = out_size_q;

  `LASS_ASSERT_IMP(a_tok_only_in_scan, tok_end.vld, state_q == S_SCAN, "token left chain outside scan")
  `LASS_ASSERT_NEXT(a_read_then_commit, ram_re, state_q == S_READ, "descriptor read without commit")
  `LASS_ASSERT_IMP(a_cmd_while_busy, cmd.op != CMD_NONE, state_q != S_IDLE, "commit while idle")
  `LASS_ASSERT_NEXT(a_result_loaded, state_q == S_DONE && out_free, out_valid_q && state_q == S_IDLE, "result not registered")

endmodule

`default_nettype wire

// File: rtl/core/lass_ram.sv
// Simple dual-port RAM with registered read, holds the packet descriptors.
// Generic; no package dependency.
`default_nettype none

module lass_ram #(
  parameter  int unsigned DATA_W = 32,
  parameter  int unsigned DEPTH  = 256,
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/lass_cell.sv
// One flow cell: service counter, queue fill, head and tail of one flow FIFO.
// Passes the scan token to its neighbour each cycle. Depends on lass_pkg.
`default_nettype none

module lass_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lass_pkg::FLOW_W-1:0] cell_id_i,
  input  lass_pkg::tok_t              tok_i,
  output lass_pkg::tok_t              tok_o,
  input  lass_pkg::cmd_t              cmd_i
);
  import lass_pkg::*;

  logic [SVC_W-1:0] svc_q, svc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  tok_t             tok_q, tok_d;
  logic [SVC_W:0]   sum;
  logic             hit;

  // Take the token over when this flow is the enqueue target, or when it
  // beats the best flow seen so far on a dequeue scan.
  always_comb begin
    tok_d = tok_i;
    if (!tok_i.deq) begin
      if (32'(tok_i.req_flow) == 32'(cell_id_i)) begin
        tok_d.found = 1'b1;
        tok_d.id    = cell_id_i;
        tok_d.cnt   = cnt_q;
        tok_d.idx   = tail_q;
      end
    end else if (cnt_q != '0 && (!tok_i.found || svc_q < tok_i.svc)) begin
      tok_d.found = 1'b1;
      tok_d.id    = cell_id_i;
      tok_d.svc   = svc_q;
      tok_d.cnt   = cnt_q;
      tok_d.idx   = head_q;
    end
  end

  always_comb begin
    hit    = (cmd_i.flow == cell_id_i);
    sum    = {1'b0, svc_q} + (SVC_W + 1)'(cmd_i.size);
    svc_d  = svc_q;
    cnt_d  = cnt_q;
    head_d = head_q;
    tail_d = tail_q;
    if (hit) begin
      unique case (cmd_i.op)
        CMD_ENQ: begin
          tail_d = next_idx(tail_q);
          cnt_d  = cnt_q + 1'b1;
        end
        CMD_DEQ: begin
          head_d = next_idx(head_q);
          cnt_d  = cnt_q - 1'b1;
          // Saturate, and clear once the FIFO runs empty.
          if (cnt_q == CNT_W'(1)) begin
            svc_d = '0;
          end else if (sum[SVC_W]) begin
            svc_d = '1;
          end else begin
            svc_d = sum[SVC_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      svc_q  <= '0;
      cnt_q  <= '0;
      head_q <= '0;
      tail_q <= '0;
      tok_q  <= '0;
    end else begin
      svc_q  <= svc_d;
      cnt_q  <= cnt_d;
      head_q <= head_d;
      tail_q <= tail_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire
